// File: sv/ivc_pkg.sv
// ----------------------------------------------------------------------------
// ivc_pkg: shared types and codes for the interlocked valve controller
// transaction payloads, command and state codes, register indexes
// ----------------------------------------------------------------------------
package ivc_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_OPENING = 3'd2;
  localparam logic [2:0] ST_CLOSING = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic CFG_DOUBLE_THROW = 1'b0;
  localparam logic CFG_TIMEOUT      = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd5000000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_us;
    logic        closed_sensor;
    logic        opened_sensor;
    logic        close_permit;
    logic        open_permit;
  } ivc_in_t;

  typedef struct packed {
    logic [2:0] valve_state;
    logic       close_drive;
    logic       open_drive;
    logic       accepted;
    logic       rejected;
    logic       ready_res;
  } ivc_out_t;

  typedef struct packed {
    logic [2:0] ctrl_state;
    logic [1:0] queued_command;
    logic       close_out;
    logic       open_out;
  } ivc_ctrl_t;

endpackage

// File: sv/ivc_step.sv
// ----------------------------------------------------------------------------
// ivc_step: next-state and result logic for one update transaction
// state decision, one-entry command queue, timeout and sensor checks
// ----------------------------------------------------------------------------
module ivc_step #(
  parameter int TIME_WIDTH = ivc_pkg::TIME_WIDTH_DEF
) (
  input  logic                  double_throw,
  input  logic [31:0]           timeout_us,
  input  ivc_pkg::ivc_in_t      item,
  input  ivc_pkg::ivc_ctrl_t    cur,
  input  logic [TIME_WIDTH-1:0] motion_start,
  input  logic [TIME_WIDTH-1:0] wait_start,
  output ivc_pkg::ivc_ctrl_t    nxt,
  output logic [TIME_WIDTH-1:0] motion_start_nxt,
  output logic [TIME_WIDTH-1:0] wait_start_nxt,
  output ivc_pkg::ivc_out_t     res
);
  import ivc_pkg::*;

  localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [CW-1:0]         now_w;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] wait_el;
  logic [TIME_WIDTH-1:0] motion_el;
  logic                  wait_to;
  logic                  motion_to;
  logic                  is_closed;
  logic                  is_opened;
  logic                  do_iss;
  logic [1:0]            iss_cmd;
  logic [1:0]            cmd;
  logic                  acc;
  logic                  rej;
  ivc_ctrl_t             st;

  assign now_w     = CW'(item.now_us);
  assign now_t     = now_w[TIME_WIDTH-1:0];
  assign wait_el   = now_t - wait_start;
  assign motion_el = now_t - motion_start;
  assign wait_to   = CW'(wait_el) > CW'(timeout_us);
  assign motion_to = CW'(motion_el) > CW'(timeout_us);

  always_comb begin
    if (double_throw) begin
      is_closed = item.closed_sensor && !item.opened_sensor;
      is_opened = item.opened_sensor && !item.closed_sensor;
    end else begin
      // single-throw: closed only once the close drive is on and the sensor made
      is_closed = item.closed_sensor && cur.close_out;
      is_opened = !item.closed_sensor;
    end
  end

  always_comb begin
    st               = cur;
    motion_start_nxt = motion_start;
    wait_start_nxt   = wait_start;
    cmd              = item.command;
    acc              = 1'b0;
    rej              = 1'b0;
    do_iss           = 1'b0;
    iss_cmd          = CMD_NONE;

    unique case (cur.ctrl_state)
      ST_IDLE: begin
        if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
          do_iss  = 1'b1;
          iss_cmd = cmd;
          acc     = 1'b1;
          cmd     = CMD_NONE;
        end
      end
      ST_WAIT: begin
        if (cur.queued_command == CMD_CLOSE) begin
          if (item.close_permit) begin
            do_iss  = 1'b1;
            iss_cmd = CMD_CLOSE;
          end else if (wait_to) begin
            st.ctrl_state = ST_INVALID;
          end
        end else if (cur.queued_command == CMD_OPEN) begin
          if (item.open_permit) begin
            do_iss  = 1'b1;
            iss_cmd = CMD_OPEN;
          end else if (wait_to) begin
            st.ctrl_state = ST_INVALID;
          end
        end else begin
          st.ctrl_state = ST_IDLE;
        end
      end
      ST_OPENING, ST_CLOSING: begin
        if ((cur.ctrl_state == ST_OPENING) ? is_opened : is_closed) begin
          st.ctrl_state = ST_IDLE;
          // queued command issues on the way back to idle
          if (cur.queued_command == CMD_OPEN || cur.queued_command == CMD_CLOSE) begin
            do_iss  = 1'b1;
            iss_cmd = cur.queued_command;
          end
        end else if (motion_to) begin
          st.ctrl_state = ST_INVALID;
        end
      end
      default: begin
        st.ctrl_state = ST_INVALID;
        if (cmd == CMD_RESET) begin
          st.close_out      = 1'b0;
          st.open_out       = 1'b0;
          st.queued_command = CMD_NONE;
          st.ctrl_state     = ST_IDLE;
        end
      end
    endcase

    if (do_iss) begin
      if (iss_cmd == CMD_CLOSE) begin
        if (item.close_permit) begin
          if (double_throw) st.open_out = 1'b0;
          st.close_out      = 1'b1;
          motion_start_nxt  = now_t;
          st.ctrl_state     = ST_CLOSING;
          st.queued_command = CMD_NONE;
        end else begin
          wait_start_nxt    = now_t;
          st.ctrl_state     = ST_WAIT;
          st.queued_command = CMD_CLOSE;
        end
      end else begin
        if (item.open_permit) begin
          st.close_out = 1'b0;
          if (double_throw) st.open_out = 1'b1;
          motion_start_nxt  = now_t;
          st.ctrl_state     = ST_OPENING;
          st.queued_command = CMD_NONE;
        end else begin
          wait_start_nxt    = now_t;
          st.ctrl_state     = ST_WAIT;
          st.queued_command = CMD_OPEN;
        end
      end
    end

    // a command that could not be taken goes to the queue once
    if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
      if (st.queued_command == CMD_NONE) st.queued_command = cmd;
      else rej = 1'b1;
    end

    // both sensors made on a double-throw valve
    if (double_throw && item.closed_sensor && item.opened_sensor) begin
      st.ctrl_state = ST_INVALID;
    end
  end

  assign nxt             = st;
  assign res.valve_state = st.ctrl_state;
  assign res.close_drive = st.close_out;
  assign res.open_drive  = st.open_out & double_throw;
  assign res.accepted    = acc;
  assign res.rejected    = rej;
  assign res.ready_res   = (st.ctrl_state == ST_IDLE);

endmodule

// File: sv/interlocked_valve_controller_top.sv
// ----------------------------------------------------------------------------
// interlocked_valve_controller_top: valve drive sequencer with interlocks
// one update transaction in, one status transaction out
// ----------------------------------------------------------------------------
// usage
//   in_*  : update transactions (command, timestamp, sensors, permits)
//   out_* : one status transaction per update (state, drives, accept and
//           reject flags, ready flag)
//   cfg_* : register writes, index 0 double_throw, index 1 timeout_us;
//           cfg_ready is always high, write only while the block is idle
// path: an accepted update lands in the input register; once the output
//   register is free or being drained, the state decision runs on it and
//   loads the output register, which then offers the status transaction
// throughput: one update per cycle while out_ready keeps up; the rate is
//   set by the single state register loop (two timestamp subtract-compares)
// reset: rst_n low clears valid flags, state goes idle, queue empty, drives
//   off, start times zero, registers back to double-throw and 5000000 us
// stall: with out_ready low the output register holds its transaction, the
//   input register still takes one more update, then in_ready drops
// ----------------------------------------------------------------------------
module interlocked_valve_controller_top #(
  parameter int TIME_WIDTH = ivc_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ivc_pkg::ivc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ivc_pkg::ivc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import ivc_pkg::*;

  // configuration registers
  logic        double_throw_r;
  logic [31:0] timeout_r;

  // input register
  ivc_in_t in_item_r;
  logic    in_v_r;

  // controller state
  ivc_ctrl_t             ctrl_r;
  ivc_ctrl_t             ctrl_nxt;
  logic [TIME_WIDTH-1:0] motion_start_r;
  logic [TIME_WIDTH-1:0] motion_start_nxt;
  logic [TIME_WIDTH-1:0] wait_start_r;
  logic [TIME_WIDTH-1:0] wait_start_nxt;

  // output register
  ivc_out_t out_r;
  ivc_out_t out_nxt;
  logic     out_v_r;

  logic advance;

  // state moves only when the held update can drop its result
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_throw_r <= 1'b1;
      timeout_r      <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DOUBLE_THROW: double_throw_r <= cfg_data[0];
        CFG_TIMEOUT:      timeout_r      <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input register, payload without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  ivc_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .double_throw    (double_throw_r),
    .timeout_us      (timeout_r),
    .item            (in_item_r),
    .cur             (ctrl_r),
    .motion_start    (motion_start_r),
    .wait_start      (wait_start_r),
    .nxt             (ctrl_nxt),
    .motion_start_nxt(motion_start_nxt),
    .wait_start_nxt  (wait_start_nxt),
    .res             (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r         <= '{ctrl_state: ST_IDLE, queued_command: CMD_NONE,
                          close_out: 1'b0, open_out: 1'b0};
      motion_start_r <= '0;
      wait_start_r   <= '0;
    end else if (advance) begin
      ctrl_r         <= ctrl_nxt;
      motion_start_r <= motion_start_nxt;
      wait_start_r   <= wait_start_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // an idle pass consumes the command, so it is never also rejected
  a_acc_rej_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.accepted && out_r.rejected))
    else $error("accepted and rejected both set");

  // only the idle state accepts a command
  a_acc_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (ctrl_r.ctrl_state != ST_IDLE) |=> !out_r.accepted)
    else $error("accepted outside idle");

  // a held update waits in the input register until it is processed
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_item_r))
    else $error("held update lost");

  // the queue never holds a reset command
  a_queue_code: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.queued_command != CMD_RESET)
    else $error("reset command queued");

endmodule

// File: verif/interlocked_valve_controller_top_test.sv
// ----------------------------------------------------------------------------
// interlocked_valve_controller_top_test: self-checking bench for the valve controller
// drives update transactions with random gaps and back-pressure, predicts each
// status transaction from its own copy of the control state and compares
// every field; register settings change between phases while the block is idle
// ----------------------------------------------------------------------------
module interlocked_valve_controller_top_test;
  import ivc_pkg::*;

  // status predictor and queue of status transactions still due
  class valve_status_board;
    logic        two_sensor;
    logic [31:0] limit_us;
    logic [2:0]  vstate;
    logic [1:0]  pend_cmd;
    logic [31:0] move_t0;
    logic [31:0] hold_t0;
    logic        drive_close;
    logic        drive_open;
    ivc_out_t    status_due[$];
    int          fails;
    int          n_checked;

    function new();
      two_sensor  = 1'b1;
      limit_us    = TIMEOUT_RST;
      vstate      = ST_IDLE;
      pend_cmd    = CMD_NONE;
      move_t0     = '0;
      hold_t0     = '0;
      drive_close = 1'b0;
      drive_open  = 1'b0;
      fails       = 0;
      n_checked   = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] d);
      if (idx == CFG_DOUBLE_THROW) two_sensor = d[0];
      else limit_us = d;
    endfunction

    function bit late(logic [31:0] now, logic [31:0] t0);
      logic [31:0] elapsed;
      elapsed = now - t0;
      return elapsed > limit_us;
    endfunction

    // start an open or close, or park it waiting for its permit
    function void start_cmd(logic [1:0] cmd, logic [31:0] now, logic cp, logic op);
      if (cmd == CMD_CLOSE) begin
        if (cp) begin
          if (two_sensor) drive_open = 1'b0;
          drive_close = 1'b1;
          move_t0     = now;
          vstate      = ST_CLOSING;
          pend_cmd    = CMD_NONE;
        end else begin
          hold_t0  = now;
          vstate   = ST_WAIT;
          pend_cmd = CMD_CLOSE;
        end
      end else if (cmd == CMD_OPEN) begin
        if (op) begin
          drive_close = 1'b0;
          if (two_sensor) drive_open = 1'b1;
          move_t0  = now;
          vstate   = ST_OPENING;
          pend_cmd = CMD_NONE;
        end else begin
          hold_t0  = now;
          vstate   = ST_WAIT;
          pend_cmd = CMD_OPEN;
        end
      end
    endfunction

    function ivc_out_t predict_status(ivc_in_t u);
      ivc_out_t   s;
      logic       is_closed;
      logic       is_opened;
      logic       done;
      logic       acc;
      logic       rej;
      logic [1:0] cmd;
      logic [1:0] q;
      acc = 1'b0;
      rej = 1'b0;
      cmd = u.command;
      if (two_sensor) begin
        is_closed = u.closed_sensor & ~u.opened_sensor;
        is_opened = u.opened_sensor & ~u.closed_sensor;
      end else begin
        // single throw: closed only counts once the close drive is on
        is_closed = u.closed_sensor & drive_close;
        is_opened = ~u.closed_sensor;
      end
      case (vstate)
        ST_IDLE: begin
          if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
            start_cmd(cmd, u.now_us, u.close_permit, u.open_permit);
            acc = 1'b1;
            cmd = CMD_NONE;
          end
        end
        ST_WAIT: begin
          if (pend_cmd == CMD_CLOSE) begin
            if (u.close_permit) start_cmd(CMD_CLOSE, u.now_us, u.close_permit, u.open_permit);
            else if (late(u.now_us, hold_t0)) vstate = ST_INVALID;
          end else if (pend_cmd == CMD_OPEN) begin
            if (u.open_permit) start_cmd(CMD_OPEN, u.now_us, u.close_permit, u.open_permit);
            else if (late(u.now_us, hold_t0)) vstate = ST_INVALID;
          end else begin
            vstate = ST_IDLE;
          end
        end
        ST_OPENING, ST_CLOSING: begin
          done = (vstate == ST_OPENING) ? is_opened : is_closed;
          if (done) begin
            // back to idle, a queued command goes out on the same update
            vstate = ST_IDLE;
            q = pend_cmd;
            if (q == CMD_OPEN || q == CMD_CLOSE)
              start_cmd(q, u.now_us, u.close_permit, u.open_permit);
          end else if (late(u.now_us, move_t0)) begin
            vstate = ST_INVALID;
          end
        end
        default: begin
          vstate = ST_INVALID;
          if (cmd == CMD_RESET) begin
            drive_close = 1'b0;
            drive_open  = 1'b0;
            pend_cmd    = CMD_NONE;
            vstate      = ST_IDLE;
          end
        end
      endcase
      if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
        if (pend_cmd == CMD_NONE) pend_cmd = cmd;
        else rej = 1'b1;
      end
      // both sensors made on a double-throw valve
      if (two_sensor && u.closed_sensor && u.opened_sensor) vstate = ST_INVALID;
      s.valve_state = vstate;
      s.close_drive = drive_close;
      s.open_drive  = drive_open & two_sensor;
      s.accepted    = acc;
      s.rejected    = rej;
      s.ready_res   = (vstate == ST_IDLE);
      return s;
    endfunction

    function void note_update(ivc_in_t u);
      status_due.push_back(predict_status(u));
    endfunction

    task report(string msg);
      if (fails < 100) $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_status(ivc_out_t got);
      ivc_out_t want;
      n_checked++;
      if (status_due.size() == 0) begin
        report($sformatf("status %0d arrived with none due", n_checked));
      end else begin
        want = status_due.pop_front();
        if (got.valve_state !== want.valve_state)
          report($sformatf("status %0d valve_state got %0d want %0d", n_checked,
                           got.valve_state, want.valve_state));
        if (got.close_drive !== want.close_drive)
          report($sformatf("status %0d close_drive got %0b want %0b", n_checked,
                           got.close_drive, want.close_drive));
        if (got.open_drive !== want.open_drive)
          report($sformatf("status %0d open_drive got %0b want %0b", n_checked,
                           got.open_drive, want.open_drive));
        if (got.accepted !== want.accepted)
          report($sformatf("status %0d accepted got %0b want %0b", n_checked,
                           got.accepted, want.accepted));
        if (got.rejected !== want.rejected)
          report($sformatf("status %0d rejected got %0b want %0b", n_checked,
                           got.rejected, want.rejected));
        if (got.ready_res !== want.ready_res)
          report($sformatf("status %0d ready_res got %0b want %0b", n_checked,
                           got.ready_res, want.ready_res));
      end
    endtask
  endclass

  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 222;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  ivc_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  ivc_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  valve_status_board sb;
  logic [31:0]       clock_us;
  bit                hold_out;
  int                send_calm;

  interlocked_valve_controller_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  function automatic ivc_in_t upd(logic [1:0] cmd, logic [31:0] now, logic cs, logic os,
                                  logic cp, logic op);
    ivc_in_t u;
    u.command       = cmd;
    u.now_us        = now;
    u.closed_sensor = cs;
    u.opened_sensor = os;
    u.close_permit  = cp;
    u.open_permit   = op;
    return u;
  endfunction

  // random update steered by the predicted state: sensors tend to report the
  // end of a motion, timestamps jump to the edge of the timeout window
  function automatic ivc_in_t make_update();
    ivc_in_t     u;
    int          r;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      clock_us = clock_us + $urandom_range(0, 15);
    end else if (r < 85 && (sb.vstate == ST_WAIT || sb.vstate == ST_OPENING ||
                            sb.vstate == ST_CLOSING)) begin
      base = (sb.vstate == ST_WAIT) ? sb.hold_t0 : sb.move_t0;
      clock_us = base + sb.limit_us + $urandom_range(0, 2) - 32'd1;
    end else if (r < 95) begin
      clock_us = $urandom;
    end
    u.now_us = clock_us;
    r = $urandom_range(0, 99);
    if (sb.vstate == ST_OPENING && r < 55) begin
      u.closed_sensor = 1'b0;
      u.opened_sensor = 1'b1;
    end else if (sb.vstate == ST_CLOSING && r < 55) begin
      u.closed_sensor = 1'b1;
      u.opened_sensor = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      u.closed_sensor = (r < 35) || (r >= 95);
      u.opened_sensor = (r >= 35 && r < 70) || (r >= 95);
    end
    u.close_permit = ($urandom_range(0, 99) < 65);
    u.open_permit  = ($urandom_range(0, 99) < 65);
    r = $urandom_range(0, 99);
    if (sb.vstate == ST_INVALID && r < 40) u.command = CMD_RESET;
    else begin
      r = $urandom_range(0, 99);
      if (r < 25) u.command = CMD_NONE;
      else if (r < 55) u.command = CMD_OPEN;
      else if (r < 85) u.command = CMD_CLOSE;
      else u.command = CMD_RESET;
    end
    return u;
  endfunction

  // offer one update and hold it until the block takes it
  task automatic send_update(ivc_in_t u);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = u;
    do @(posedge clk); while (!in_ready);
    sb.note_update(u);
  endtask

  task automatic sender_idle(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_paced(ivc_in_t u);
    send_update(u);
    sender_idle(pick_gap(send_calm));
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // every update yields a status, so an empty queue means the block is idle
  task automatic wait_drained();
    sender_idle(1);
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    // reset ignored in idle, open with permit, close queued, second rejected
    send_paced(upd(CMD_NONE,  32'd0, 1'b1, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_RESET, 32'd1, 1'b1, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_OPEN,  32'd2, 1'b1, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_CLOSE, 32'd3, 1'b0, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_OPEN,  32'd4, 1'b0, 1'b0, 1'b1, 1'b1));
    // opened: queued close issues on return to idle
    send_paced(upd(CMD_NONE,  32'd5, 1'b0, 1'b1, 1'b1, 1'b1));
    send_paced(upd(CMD_NONE,  32'd6, 1'b1, 1'b0, 1'b1, 1'b1));
    // open without permit waits; wait timeout right at and past the limit
    send_paced(upd(CMD_OPEN,  32'd7, 1'b1, 1'b0, 1'b1, 1'b0));
    send_paced(upd(CMD_CLOSE, 32'd8, 1'b1, 1'b0, 1'b1, 1'b0));
    send_paced(upd(CMD_NONE,  32'd5000007, 1'b1, 1'b0, 1'b1, 1'b0));
    send_paced(upd(CMD_NONE,  32'd5000008, 1'b1, 1'b0, 1'b1, 1'b0));
    send_paced(upd(CMD_OPEN,  32'd5000009, 1'b1, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_RESET, 32'd5000010, 1'b1, 1'b0, 1'b1, 1'b1));
    // motion timeout across the timestamp wrap
    send_paced(upd(CMD_CLOSE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1));
    send_paced(upd(CMD_NONE,  32'd4999999, 1'b0, 1'b1, 1'b1, 1'b1));
    send_paced(upd(CMD_NONE,  32'd5000000, 1'b0, 1'b1, 1'b1, 1'b1));
    send_paced(upd(CMD_RESET, 32'd5000001, 1'b1, 1'b0, 1'b1, 1'b1));
    // both sensors made, also on the reset update itself
    send_paced(upd(CMD_NONE,  32'd5000002, 1'b1, 1'b1, 1'b1, 1'b1));
    send_paced(upd(CMD_RESET, 32'd5000003, 1'b1, 1'b1, 1'b1, 1'b1));
    send_paced(upd(CMD_RESET, 32'd5000004, 1'b0, 1'b0, 1'b0, 1'b0));
    // permit arrives while waiting: queue frees and takes the new command
    send_paced(upd(CMD_CLOSE, 32'd5000005, 1'b1, 1'b0, 1'b0, 1'b1));
    send_paced(upd(CMD_OPEN,  32'd5000006, 1'b1, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_NONE,  32'd5000007, 1'b1, 1'b0, 1'b1, 1'b1));
    send_paced(upd(CMD_NONE,  32'd5000008, 1'b0, 1'b1, 1'b1, 1'b1));
  endtask

  // receiver: random back-pressure plus one long hold on request
  initial begin
    int n;
    int calm;
    calm = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        n = pick_gap(calm);
        if (n == 0) out_ready = 1'b1;
        else begin
          out_ready = 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_status(out_data);
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic        dt;
    logic [31:0] lim;
    sb        = new();
    hold_out  = 1'b0;
    send_calm = 0;
    clock_us  = '0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DOUBLE_THROW;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed checks under the reset settings
    run_directed();
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin dt = 1'b1; lim = TIMEOUT_RST; end
        1: begin dt = 1'b0; lim = 32'd0; end
        2: begin dt = 1'b1; lim = 32'd0; end
        3: begin dt = 1'b0; lim = 32'hFFFF_FFFF; end
        4: begin dt = 1'b1; lim = 32'hFFFF_FFFF; end
        5: begin dt = 1'b0; lim = $urandom_range(1, 60); end
        6: begin dt = 1'b1; lim = $urandom_range(1, 60); end
        default: begin dt = 1'($urandom_range(0, 1)); lim = $urandom; end
      endcase
      write_reg(CFG_DOUBLE_THROW, {31'd0, dt});
      write_reg(CFG_TIMEOUT, lim);
      // long receiver hold so the block fills and stalls its input
      if (ph == 2) hold_out = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_paced(make_update());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.status_due.size() != 0)
      sb.report($sformatf("%0d status transactions never arrived", sb.status_due.size()));
    if (sb.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
